/* design/alu_pkg.sv */
// ----------------------------------------------------------------------------
// alu_pkg: shared types and constants for the 8-bit ALU with status flags
// Operation codes, field widths and flag bit positions.
// ----------------------------------------------------------------------------
package alu_pkg;

  localparam int unsigned KindW = 4;
  localparam int unsigned DataW = 8;
  localparam int unsigned FlagW = 4;

  // flag bit positions within flags_in / flags_out
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagV = 2;
  localparam int unsigned FlagN = 3;

  localparam int unsigned SignBit = DataW - 1;
  localparam int unsigned Bit6    = DataW - 2;

  typedef enum logic [KindW-1:0] {
    ALU_ADC  = 4'd0,
    ALU_CMP  = 4'd1,
    ALU_INC  = 4'd2,
    ALU_DEC  = 4'd3,
    ALU_LOAD = 4'd4,
    ALU_AND  = 4'd5,
    ALU_OR   = 4'd6,
    ALU_XOR  = 4'd7,
    ALU_ASL  = 4'd8,
    ALU_LSR  = 4'd9,
    ALU_ROL  = 4'd10,
    ALU_ROR  = 4'd11,
    ALU_BIT  = 4'd12
  } alu_op_e;

  typedef logic [DataW-1:0] alu_data_t;
  typedef logic [FlagW-1:0] alu_flags_t;

endpackage

/* design/alu_if.sv */
// ----------------------------------------------------------------------------
// alu_req_if / alu_rsp_if: valid/ready channels of the ALU
// Request carries the operation and operands, response the result and flags.
// ----------------------------------------------------------------------------
interface alu_req_if;
  import alu_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  alu_data_t              register_value;
  alu_data_t              operand_value;
  alu_flags_t             flags_in;

  modport source (
    output valid, kind, register_value, operand_value, flags_in,
    input  ready
  );

  modport sink (
    input  valid, kind, register_value, operand_value, flags_in,
    output ready
  );
endinterface

interface alu_rsp_if;
  import alu_pkg::*;

  logic       valid;
  logic       ready;
  alu_data_t  result;
  alu_flags_t flags_out;

  modport source (
    output valid, result, flags_out,
    input  ready
  );

  modport sink (
    input  valid, result, flags_out,
    output ready
  );
endinterface

/* design/cpu_alu_with_status_flags.sv */
// ----------------------------------------------------------------------------
// cpu_alu_with_status_flags: 8-bit processor ALU with NZCV status flags
// Binary-mode add, compare, inc/dec, load, logic, shifts, rotates and bit
// test; flags an operation leaves alone pass through unchanged.
// ----------------------------------------------------------------------------
//
//  Port    | Dir | Fields                                            | Transfer
//  --------+-----+---------------------------------------------------+-------------
//  req_i   | in  | kind, register_value, operand_value, flags_in     | valid&ready
//  rsp_o   | out | result, flags_out                                 | valid&ready
//
//  Two register stages: the request is captured in an input register, the
//  ALU is combinational adders plus a mux, and the answer lands in the result
//  register, which drives the response valid and payload; one operation is
//  taken every cycle while the response side keeps up.
//  A stalled response holds the result register; the input register still
//  takes a request while it is empty, so a stall backs up one stage at a time.
//  Reset clears both valid bits; payload registers are not reset.
//
module cpu_alu_with_status_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  alu_req_if.sink         req_i,
  alu_rsp_if.source       rsp_o
);
  import alu_pkg::*;

  // input register
  logic       in_valid_q;
  alu_op_e    in_kind_q;
  alu_data_t  in_reg_q;
  alu_data_t  in_opnd_q;
  alu_flags_t in_flags_q;

  // result register
  logic       out_valid_q;
  alu_data_t  out_result_q;
  alu_flags_t out_flags_q;

  logic       out_free;
  logic       in_advance;
  logic       in_load;

  alu_data_t  alu_result_d;
  alu_flags_t alu_flags_d;

  logic [DataW:0] add_sum;
  logic [DataW:0] cmp_diff;
  logic           cin;

  // Handshake: the result register is free when empty or being drained;
  // the input register moves on whenever the result register is free.
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign in_advance = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;
  assign in_load    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Capture the request payload on transfer.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_kind_q  <= alu_op_e'(req_i.kind);
      in_reg_q   <= req_i.register_value;
      in_opnd_q  <= req_i.operand_value;
      in_flags_q <= req_i.flags_in;
    end
  end

  // Shared carry chains: add with carry, and register minus operand.
  assign cin      = in_flags_q[FlagC];
  assign add_sum  = {1'b0, in_reg_q} + {1'b0, in_opnd_q} + {{DataW{1'b0}}, cin};
  assign cmp_diff = {1'b0, in_reg_q} - {1'b0, in_opnd_q};

  always_comb begin
    alu_result_d = in_reg_q;
    alu_flags_d  = in_flags_q;
    unique case (in_kind_q)
      ALU_ADC: begin
        alu_result_d       = add_sum[DataW-1:0];
        alu_flags_d[FlagC] = add_sum[DataW];
        alu_flags_d[FlagV] = ~(in_reg_q[SignBit] ^ in_opnd_q[SignBit])
                           & (in_reg_q[SignBit] ^ add_sum[SignBit]);
      end
      ALU_CMP: begin
        // carry set means no borrow: register >= operand
        alu_flags_d[FlagC] = ~cmp_diff[DataW];
      end
      ALU_INC:  alu_result_d = in_opnd_q + alu_data_t'(1);
      ALU_DEC:  alu_result_d = in_opnd_q - alu_data_t'(1);
      ALU_LOAD: alu_result_d = in_opnd_q;
      ALU_AND:  alu_result_d = in_reg_q & in_opnd_q;
      ALU_OR:   alu_result_d = in_reg_q | in_opnd_q;
      ALU_XOR:  alu_result_d = in_reg_q ^ in_opnd_q;
      ALU_ASL: begin
        alu_result_d       = {in_opnd_q[DataW-2:0], 1'b0};
        alu_flags_d[FlagC] = in_opnd_q[SignBit];
      end
      ALU_LSR: begin
        alu_result_d       = {1'b0, in_opnd_q[DataW-1:1]};
        alu_flags_d[FlagC] = in_opnd_q[0];
      end
      ALU_ROL: begin
        alu_result_d       = {in_opnd_q[DataW-2:0], cin};
        alu_flags_d[FlagC] = in_opnd_q[SignBit];
      end
      ALU_ROR: begin
        alu_result_d       = {cin, in_opnd_q[DataW-1:1]};
        alu_flags_d[FlagC] = in_opnd_q[0];
      end
      ALU_BIT: begin
        alu_flags_d[FlagV] = in_opnd_q[Bit6];
      end
      default: ;  // unused codes: pass register and flags through
    endcase

    // N and Z: compare looks at the difference, bit test at the mask and
    // operand bit 7, unused codes leave them; everything else the result.
    priority if (in_kind_q == ALU_CMP) begin
      alu_flags_d[FlagZ] = (cmp_diff[DataW-1:0] == '0);
      alu_flags_d[FlagN] = cmp_diff[SignBit];
    end else if (in_kind_q == ALU_BIT) begin
      alu_flags_d[FlagZ] = ((in_reg_q & in_opnd_q) == '0);
      alu_flags_d[FlagN] = in_opnd_q[SignBit];
    end else if (in_kind_q > ALU_BIT) begin
      alu_flags_d[FlagZ] = in_flags_q[FlagZ];
      alu_flags_d[FlagN] = in_flags_q[FlagN];
    end else begin
      alu_flags_d[FlagZ] = (alu_result_d == '0);
      alu_flags_d[FlagN] = alu_result_d[SignBit];
    end
  end

  // Advance into the result register; hold it while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (in_advance) begin
      out_result_q <= alu_result_d;
      out_flags_q  <= alu_flags_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.result    = out_result_q;
  assign rsp_o.flags_out = out_flags_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // an operation leaving the input register always shows up as a response
  a_advance_gives_rsp: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_advance |=> out_valid_q
  ) else $error("advanced operation did not reach the result register");

  // compare returns the register value unchanged
  a_cmp_keeps_reg: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_advance && in_kind_q == ALU_CMP) |=> (out_result_q == $past(in_reg_q))
  ) else $error("compare altered the result byte");

  // unused codes leave the flags as they came in
  a_unused_keeps_flags: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_advance && in_kind_q > ALU_BIT) |=> (out_flags_q == $past(in_flags_q))
  ) else $error("unused operation code changed the flags");

  // logical shift right never leaves N set
  a_lsr_clears_n: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_advance && in_kind_q == ALU_LSR) |=> !out_flags_q[FlagN]
  ) else $error("LSR produced a negative flag");

endmodule
